// ===== hdl/etl_pkg.sv =====
// Shared types, character codes and token kinds for the expression token lexer.
`default_nettype none

package etl_pkg;

   // Lexer position inside the current token
   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_ALPHA   = 3'd1,
      ST_INT     = 3'd2,
      ST_DOTLEAD = 3'd3,
      ST_FRAC    = 3'd4,
      ST_EXPE    = 3'd5,
      ST_EXPSIGN = 3'd6,
      ST_EXPDIG  = 3'd7
   } lex_state_type;

   // Pending first byte of a mergeable pair
   typedef enum logic [1:0] {
      PAIR_NONE = 2'd0,
      PAIR_STAR = 2'd1,
      PAIR_CMP  = 2'd2
   } pair_lead_type;

   localparam logic [1:0] KIND_ALPHA  = 2'd0;
   localparam logic [1:0] KIND_NUMBER = 2'd1;
   localparam logic [1:0] KIND_PUNCT  = 2'd2;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_UNDER = 8'h5f;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_LOW_E = 8'h65;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_BANG  = 8'h21;

   typedef struct packed {
      lex_state_type lex;
      pair_lead_type pair;
      logic          failed;
   } lex_ctx_type;

   localparam lex_ctx_type CTX_RESET = '{lex: ST_IDLE, pair: PAIR_NONE, failed: 1'b0};

   typedef struct packed {
      logic       dropped;
      logic       token_start;
      logic [1:0] token_kind;
      logic       error;
   } lex_label_type;

endpackage

`default_nettype wire

// ===== hdl/etl_classify.sv =====
// Combinational byte classifier: labels one byte and computes the next lexer context.
`default_nettype none

module etl_classify
   import etl_pkg::*;
(
   input  wire logic [7:0]    char_in,
   input  wire logic          last,
   input  wire lex_ctx_type   ctx,
   output lex_ctx_type        ctx_next,
   output lex_label_type      label
);

   logic          is_digit;
   logic          is_letter;
   logic          is_exp;
   logic          cont;
   logic          err;
   logic          tail_err;
   logic [1:0]    kind;
   lex_state_type s;
   lex_ctx_type   upd;

   assign is_digit  = (char_in >= 8'h30) && (char_in <= 8'h39);
   assign is_letter = ((char_in >= 8'h61) && (char_in <= 8'h7a)) ||
                      ((char_in >= 8'h41) && (char_in <= 8'h5a));
   assign is_exp    = (char_in == CH_LOW_E) || (char_in == CH_UP_E);

   always_comb begin
      cont  = 1'b0;
      err   = 1'b0;
      kind  = KIND_ALPHA;
      s     = ctx.lex;
      upd   = ctx;
      label = '0;

      if (ctx.failed || char_in == CH_SPACE) begin
         label.dropped = 1'b1;
      end else begin
         case (ctx.lex)
            ST_ALPHA: begin
               if (is_letter || is_digit || char_in == CH_UNDER) cont = 1'b1;
            end
            ST_INT: begin
               kind = KIND_NUMBER;
               if (is_digit) begin
                  cont = 1'b1;
               end else if (char_in == CH_DOT) begin
                  cont = 1'b1;
                  s    = ST_FRAC;
               end else if (is_exp) begin
                  cont = 1'b1;
                  s    = ST_EXPE;
               end
            end
            ST_FRAC: begin
               kind = KIND_NUMBER;
               if (is_digit) begin
                  cont = 1'b1;
               end else if (is_exp) begin
                  cont = 1'b1;
                  s    = ST_EXPE;
               end
            end
            ST_EXPDIG: begin
               kind = KIND_NUMBER;
               if (is_digit) cont = 1'b1;
            end
            ST_DOTLEAD: begin
               kind = KIND_NUMBER;
               if (is_digit) begin
                  cont = 1'b1;
                  s    = ST_FRAC;
               end else begin
                  err = 1'b1;
               end
            end
            ST_EXPE: begin
               kind = KIND_NUMBER;
               if (char_in == CH_PLUS || char_in == CH_MINUS) begin
                  cont = 1'b1;
                  s    = ST_EXPSIGN;
               end else if (is_digit) begin
                  cont = 1'b1;
                  s    = ST_EXPDIG;
               end else begin
                  err = 1'b1;
               end
            end
            ST_EXPSIGN: begin
               kind = KIND_NUMBER;
               if (is_digit) begin
                  cont = 1'b1;
                  s    = ST_EXPDIG;
               end else begin
                  err = 1'b1;
               end
            end
            default: begin
               // idle: second byte of a pair merges into the open token
               if ((ctx.pair == PAIR_STAR && char_in == CH_STAR) ||
                   (ctx.pair == PAIR_CMP && char_in == CH_EQ)) begin
                  cont = 1'b1;
                  kind = KIND_PUNCT;
               end
               s = ST_IDLE;
            end
         endcase

         if (err) begin
            upd.failed = 1'b1;
            kind       = KIND_NUMBER;
         end else if (cont) begin
            upd.pair = PAIR_NONE;
         end else begin
            label.token_start = 1'b1;
            upd.pair          = PAIR_NONE;
            if (is_letter || char_in == CH_UNDER) begin
               s    = ST_ALPHA;
               kind = KIND_ALPHA;
            end else if (is_digit) begin
               s    = ST_INT;
               kind = KIND_NUMBER;
            end else if (char_in == CH_DOT) begin
               s    = ST_DOTLEAD;
               kind = KIND_NUMBER;
            end else begin
               s    = ST_IDLE;
               kind = KIND_PUNCT;
               if (char_in == CH_STAR) begin
                  upd.pair = PAIR_STAR;
               end else if (char_in == CH_LT || char_in == CH_GT ||
                            char_in == CH_EQ || char_in == CH_BANG) begin
                  upd.pair = PAIR_CMP;
               end
            end
         end
         upd.lex          = s;
         label.token_kind = kind;
      end

      // number still waiting for a digit when the expression ends
      tail_err = last && !upd.failed &&
                 (upd.lex == ST_DOTLEAD || upd.lex == ST_EXPE || upd.lex == ST_EXPSIGN);
      label.error = err || tail_err;

      ctx_next = last ? CTX_RESET : upd;
   end

endmodule

`default_nettype wire

// ===== hdl/expression_token_lexer.sv =====
// Top level of the expression token lexer: context register, classifier and result register.
//
//   channel | ports                                            | direction
//   --------+--------------------------------------------------+----------
//   req     | req_valid, req_ready, req_char_in, req_last      | in
//   rsp     | rsp_valid, rsp_ready, rsp_char_out, rsp_dropped, | out
//           | rsp_token_start, rsp_token_kind, rsp_error,      |
//           | rsp_last_out                                     |
//
// One word per cycle while rsp does not stall: each byte is labeled by the
// classifier in the cycle it is taken, and the context register (state, pair
// lead, failure) updates at that same edge, so the next byte sees the new context.
// The label leaves on rsp from the output register in the cycle after the word is taken.
// Results sit in a single output register; a new word is taken whenever that
// register is empty or being drained in the same cycle.
// Synchronous reset empties the output register and returns to idle context.
// A stall on rsp holds the result and the context unchanged.
`default_nettype none

module expression_token_lexer
   import etl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_dropped,
   output logic            rsp_token_start,
   output logic [1:0]      rsp_token_kind,
   output logic            rsp_error,
   output logic            rsp_last_out
);

   lex_ctx_type   ctx_ff;
   lex_ctx_type   ctx_in;
   lex_label_type label_in;
   lex_label_type label_ff;
   logic          valid_ff;
   logic [7:0]    char_ff;
   logic          last_ff;
   logic          take;

   // output register empty or draining this cycle
   assign req_ready = !valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   etl_classify u_classify (
      .char_in  (req_char_in),
      .last     (req_last),
      .ctx      (ctx_ff),
      .ctx_next (ctx_in),
      .label    (label_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff   <= CTX_RESET;
         valid_ff <= 1'b0;
      end else begin
         if (take) ctx_ff <= ctx_in;
         if (take) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (take) begin
         label_ff <= label_in;
         char_ff  <= req_char_in;
         last_ff  <= req_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_char_out    = char_ff;
   assign rsp_dropped     = label_ff.dropped;
   assign rsp_token_start = label_ff.token_start;
   assign rsp_token_kind  = label_ff.token_kind;
   assign rsp_error       = label_ff.error;
   assign rsp_last_out    = last_ff;

   a_drop_no_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> !rsp_token_start)
      else $error("dropped word marked as token start");

   a_error_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> (rsp_token_kind == KIND_NUMBER) || rsp_dropped)
      else $error("error raised on a non-number word");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      take && req_last |=> ctx_ff == CTX_RESET)
      else $error("context not cleared after last word");

   a_failed_drops: assert property (@(posedge clock) disable iff (reset)
      take && ctx_ff.failed |=> rsp_valid && rsp_dropped && !rsp_error)
      else $error("word after failure not dropped");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the expression token lexer: directed table, then random expressions.
`timescale 1ns / 1ps

module tb
   import etl_pkg::*;
();

   // One labeled byte as it leaves the rsp channel
   typedef struct packed {
      logic [7:0] char_out;
      logic       dropped;
      logic       token_start;
      logic [1:0] token_kind;
      logic       error;
      logic       last_out;
   } lex_word_type;

   // Directed row: byte, end flag, and a hand-written label where it is obvious
   typedef struct packed {
      logic [7:0]   ch;
      logic         last;
      logic         typed;
      lex_word_type label;
   } stim_row_type;

   localparam int           CYCLE_LIMIT  = 300000;
   localparam int           WORDS_PER_MODE = 400;
   localparam int           DRAIN_CYCLES = 4;
   localparam lex_word_type NO_LABEL     = '0;

   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;

   // Walk through the extremes, spaces inside a token, a leading-dot number with
   // a signed exponent, pair merges (including the triple star), a malformed
   // leading dot that kills the rest of the expression, and an exponent left
   // open at the end where the closing byte is a space.
   localparam stim_row_type DIRECTED_ROWS [0:24] = '{
      '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, KIND_PUNCT, 1'b0, 1'b0}},
      '{8'hff, 1'b1, 1'b1, '{8'hff, 1'b0, 1'b1, KIND_PUNCT, 1'b0, 1'b1}},
      '{"_",   1'b0, 1'b0, NO_LABEL},
      '{"Z",   1'b0, 1'b0, NO_LABEL},
      '{" ",   1'b0, 1'b1, '{CH_SPACE, 1'b1, 1'b0, KIND_ALPHA, 1'b0, 1'b0}},
      '{"9",   1'b0, 1'b0, NO_LABEL},
      '{"*",   1'b0, 1'b0, NO_LABEL},
      '{"*",   1'b0, 1'b0, NO_LABEL},
      '{"*",   1'b0, 1'b0, NO_LABEL},
      '{".",   1'b0, 1'b0, NO_LABEL},
      '{"5",   1'b0, 1'b0, NO_LABEL},
      '{"e",   1'b0, 1'b0, NO_LABEL},
      '{"-",   1'b0, 1'b0, NO_LABEL},
      '{"7",   1'b0, 1'b0, NO_LABEL},
      '{"<",   1'b0, 1'b0, NO_LABEL},
      '{"=",   1'b0, 1'b0, NO_LABEL},
      '{"=",   1'b0, 1'b0, NO_LABEL},
      '{"=",   1'b0, 1'b0, NO_LABEL},
      '{".",   1'b0, 1'b0, NO_LABEL},
      '{"x",   1'b0, 1'b1, '{"x", 1'b0, 1'b0, KIND_NUMBER, 1'b1, 1'b0}},
      '{"1",   1'b0, 1'b1, '{"1", 1'b1, 1'b0, KIND_ALPHA, 1'b0, 1'b0}},
      '{"2",   1'b1, 1'b1, '{"2", 1'b1, 1'b0, KIND_ALPHA, 1'b0, 1'b1}},
      '{"4",   1'b0, 1'b0, NO_LABEL},
      '{"E",   1'b0, 1'b0, NO_LABEL},
      '{" ",   1'b1, 1'b1, '{CH_SPACE, 1'b1, 1'b0, KIND_ALPHA, 1'b1, 1'b1}}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_in = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_char_out;
   logic       rsp_dropped;
   logic       rsp_token_start;
   logic [1:0] rsp_token_kind;
   logic       rsp_error;
   logic       rsp_last_out;

   // Lexer context as the testbench sees it, advanced once per accepted word
   lex_state_type lex_now = ST_IDLE;
   pair_lead_type pair_now = PAIR_NONE;
   logic          expr_failed = 1'b0;

   lex_word_type labels_due[$];   // labels still owed by the DUT, oldest first
   logic [7:0]   expr_bytes[$];   // bytes of the expression being sent
   int           fail_count = 0;
   int           cycle_count = 0;
   int           words_sent = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;

   expression_token_lexer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_out    (rsp_char_out),
      .rsp_dropped     (rsp_dropped),
      .rsp_token_start (rsp_token_start),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_error       (rsp_error),
      .rsp_last_out    (rsp_last_out)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_exp_mark(input logic [7:0] c);
      return c == CH_LOW_E || c == CH_UP_E;
   endfunction

   function automatic logic [7:0] rand_letter();
      return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'($urandom_range(48, 57));
   endfunction

   // Label one byte and advance the lexer context. Spaces and bytes after a
   // failure leave the context alone; the end flag returns it to idle.
   function automatic lex_word_type label_byte(input logic [7:0] c, input logic is_last);
      lex_word_type  w;
      lex_state_type nxt;
      logic          cont;
      logic          err;
      w = '0;
      w.char_out = c;
      w.last_out = is_last;
      cont = 1'b0;
      err = 1'b0;
      if (expr_failed || c == CH_SPACE) begin
         w.dropped = 1'b1;
      end else begin
         nxt = lex_now;
         case (lex_now)
            ST_ALPHA: begin
               if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
                  cont = 1'b1;
                  w.token_kind = KIND_ALPHA;
               end
            end
            ST_INT: begin
               w.token_kind = KIND_NUMBER;
               if (is_digit(c)) begin
                  cont = 1'b1;
               end else if (c == CH_DOT) begin
                  cont = 1'b1;
                  nxt = ST_FRAC;
               end else if (is_exp_mark(c)) begin
                  cont = 1'b1;
                  nxt = ST_EXPE;
               end
            end
            ST_FRAC: begin
               w.token_kind = KIND_NUMBER;
               if (is_digit(c)) begin
                  cont = 1'b1;
               end else if (is_exp_mark(c)) begin
                  cont = 1'b1;
                  nxt = ST_EXPE;
               end
            end
            ST_EXPDIG: begin
               w.token_kind = KIND_NUMBER;
               cont = is_digit(c);
            end
            ST_DOTLEAD: begin
               w.token_kind = KIND_NUMBER;
               if (is_digit(c)) begin
                  cont = 1'b1;
                  nxt = ST_FRAC;
               end else begin
                  err = 1'b1;
               end
            end
            ST_EXPE: begin
               w.token_kind = KIND_NUMBER;
               if (c == CH_PLUS || c == CH_MINUS) begin
                  cont = 1'b1;
                  nxt = ST_EXPSIGN;
               end else if (is_digit(c)) begin
                  cont = 1'b1;
                  nxt = ST_EXPDIG;
               end else begin
                  err = 1'b1;
               end
            end
            ST_EXPSIGN: begin
               w.token_kind = KIND_NUMBER;
               if (is_digit(c)) begin
                  cont = 1'b1;
                  nxt = ST_EXPDIG;
               end else begin
                  err = 1'b1;
               end
            end
            default: begin
               // between tokens: only the second byte of a pair continues
               if ((pair_now == PAIR_STAR && c == CH_STAR) ||
                   (pair_now == PAIR_CMP && c == CH_EQ)) begin
                  cont = 1'b1;
                  w.token_kind = KIND_PUNCT;
               end
               nxt = ST_IDLE;
            end
         endcase

         if (err) begin
            expr_failed = 1'b1;
            w.token_start = 1'b0;
            w.token_kind = KIND_NUMBER;
         end else if (cont) begin
            pair_now = PAIR_NONE;
         end else begin
            w.token_start = 1'b1;
            pair_now = PAIR_NONE;
            if (is_letter(c) || c == CH_UNDER) begin
               nxt = ST_ALPHA;
               w.token_kind = KIND_ALPHA;
            end else if (is_digit(c)) begin
               nxt = ST_INT;
               w.token_kind = KIND_NUMBER;
            end else if (c == CH_DOT) begin
               nxt = ST_DOTLEAD;
               w.token_kind = KIND_NUMBER;
            end else begin
               nxt = ST_IDLE;
               w.token_kind = KIND_PUNCT;
               if (c == CH_STAR) begin
                  pair_now = PAIR_STAR;
               end else if (c == CH_LT || c == CH_GT || c == CH_EQ || c == CH_BANG) begin
                  pair_now = PAIR_CMP;
               end
            end
         end
         lex_now = nxt;
      end

      w.error = err;
      if (is_last) begin
         // a number still waiting for a digit is an error on the closing byte
         if (!expr_failed &&
             (lex_now == ST_DOTLEAD || lex_now == ST_EXPE || lex_now == ST_EXPSIGN)) begin
            w.error = 1'b1;
         end
         lex_now = ST_IDLE;
         pair_now = PAIR_NONE;
         expr_failed = 1'b0;
      end
      return w;
   endfunction

   // Present one word on req and hold it until taken. A random idle gap may
   // come first; with no gap, valid simply stays high from the previous word.
   // On acceptance the expected label is queued (the typed one if given).
   task automatic send_word(input logic [7:0] c, input logic is_last, input logic typed,
                            input lex_word_type label);
      int           gap;
      lex_word_type predicted;
      gap = 0;
      while (gap < 30 && $urandom_range(0, 99) < send_idle_pct) begin
         gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      req_last <= is_last;
      do @(posedge clock); while (!req_ready);
      predicted = label_byte(c, is_last);
      labels_due.push_back(typed ? label : predicted);
      words_sent++;
   endtask

   // Mostly well-formed expressions with random content: identifiers, numbers
   // of every shape (about one in ten drawn bad, losing the digits after a leading dot or an exponent), pairs, single
   // punctuation and spaces. One in eight is plain byte noise.
   task automatic build_expression();
      int         ntok;
      int         n;
      logic       bad;
      logic       lead_dot;
      logic [7:0] lead;
      expr_bytes.delete();
      if ($urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 8);
         repeat (n) expr_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      ntok = $urandom_range(1, 10);
      repeat (ntok) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               expr_bytes.push_back($urandom_range(0, 4) == 0 ? CH_UNDER : rand_letter());
               repeat ($urandom_range(0, 4)) begin
                  case ($urandom_range(0, 2))
                     0: expr_bytes.push_back(rand_letter());
                     1: expr_bytes.push_back(rand_digit());
                     default: expr_bytes.push_back(CH_UNDER);
                  endcase
               end
            end
            2, 3: begin
               lead_dot = ($urandom_range(0, 4) == 0);
               bad = ($urandom_range(0, 9) == 0);
               if (lead_dot) begin
                  expr_bytes.push_back(CH_DOT);
                  if (!bad) expr_bytes.push_back(rand_digit());
               end else begin
                  repeat ($urandom_range(1, 3)) expr_bytes.push_back(rand_digit());
                  if ($urandom_range(0, 2) == 0) begin
                     expr_bytes.push_back(CH_DOT);
                     repeat ($urandom_range(0, 2)) expr_bytes.push_back(rand_digit());
                  end
               end
               if ((!lead_dot || !bad) && $urandom_range(0, 2) == 0) begin
                  expr_bytes.push_back($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
                  if ($urandom_range(0, 1)) begin
                     expr_bytes.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                  end
                  if (!bad) begin
                     repeat ($urandom_range(1, 2)) expr_bytes.push_back(rand_digit());
                  end
               end
            end
            4, 5: begin
               case ($urandom_range(0, 4))
                  0: lead = CH_STAR;
                  1: lead = CH_LT;
                  2: lead = CH_GT;
                  3: lead = CH_EQ;
                  default: lead = CH_BANG;
               endcase
               expr_bytes.push_back(lead);
               expr_bytes.push_back(lead == CH_STAR ? CH_STAR : CH_EQ);
            end
            6: begin
               case ($urandom_range(0, 9))
                  0: expr_bytes.push_back(CH_PLUS);
                  1: expr_bytes.push_back(CH_MINUS);
                  2: expr_bytes.push_back(CH_STAR);
                  3: expr_bytes.push_back(CH_LT);
                  4: expr_bytes.push_back(CH_GT);
                  5: expr_bytes.push_back(CH_EQ);
                  6: expr_bytes.push_back(CH_BANG);
                  7: expr_bytes.push_back(CH_SLASH);
                  8: expr_bytes.push_back(CH_LPAREN);
                  default: expr_bytes.push_back(CH_RPAREN);
               endcase
            end
            7: expr_bytes.push_back(8'($urandom_range(0, 255)));
            default: repeat ($urandom_range(1, 2)) expr_bytes.push_back(CH_SPACE);
         endcase
      end
      // trailing space: end-of-expression checks on a dropped byte
      if ($urandom_range(0, 6) == 0) expr_bytes.push_back(CH_SPACE);
   endtask

   // rsp side: compare every taken word with the oldest owed label, then pick
   // the next cycle's ready. Sampling happens before this edge's updates land.
   always @(posedge clock) begin
      lex_word_type got;
      lex_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_char_out, rsp_dropped, rsp_token_start, rsp_token_kind,
                 rsp_error, rsp_last_out};
         if (labels_due.size() == 0) begin
            $error("unexpected word: char_out %0h", got.char_out);
            fail_count++;
         end else begin
            want = labels_due.pop_front();
            if (got.char_out !== want.char_out) begin
               $error("char_out: expected %0h, got %0h", want.char_out, got.char_out);
               fail_count++;
            end
            if (got.dropped !== want.dropped) begin
               $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
               fail_count++;
            end
            if (got.token_start !== want.token_start) begin
               $error("token_start: expected %0d, got %0d", want.token_start,
                      got.token_start);
               fail_count++;
            end
            if (got.token_kind !== want.token_kind) begin
               $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
               fail_count++;
            end
            if (got.error !== want.error) begin
               $error("error: expected %0d, got %0d", want.error, got.error);
               fail_count++;
            end
            if (got.last_out !== want.last_out) begin
               $error("last_out: expected %0d, got %0d", want.last_out, got.last_out);
               fail_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Watchdog: a hang or a lost word ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("expression_token_lexer: mismatch");
         $finish;
      end
   end

   initial begin
      int mode_idx;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling on either side
      foreach (DIRECTED_ROWS[i]) begin
         send_word(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].label);
      end

      // random expressions under four idling modes: none, sender gaps,
      // receiver stalls, both together
      for (mode_idx = 0; mode_idx < 4; mode_idx++) begin
         case (mode_idx)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         while (words_sent < $size(DIRECTED_ROWS) + WORDS_PER_MODE * (mode_idx + 1)) begin
            build_expression();
            foreach (expr_bytes[k]) begin
               send_word(expr_bytes[k], k == expr_bytes.size() - 1, 1'b0, NO_LABEL);
            end
         end
      end
      req_valid <= 1'b0;

      while (labels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("expression_token_lexer: match");
      end else begin
         $display("expression_token_lexer: mismatch");
      end
      $finish;
   end

endmodule
